// File: rtl/bdmd_pkg.sv
// Shared types and constants for the bar-delimited message deframer.
package bdmd_pkg;

    // Byte codes seen in the stream.
    localparam logic [7:0] CH_VERSION = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_BAR     = 8'h7C;

    // Reset value of the largest accepted payload length.
    localparam logic [6:0] MAX_LENGTH_RESET = 7'd99;

    // Depth of the result queue in entries.
    localparam int QUEUE_DEPTH = 4;

    typedef logic [6:0] length_t;
    typedef logic [4:0] field_idx_t;

    typedef enum logic [2:0] {
        PH_VERSION,
        PH_BAR1,
        PH_TENS,
        PH_UNITS,
        PH_BAR2,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_END    = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_VERSION   = 3'd1,
        ST_SEPARATOR = 3'd2,
        ST_DIGIT     = 3'd3,
        ST_RANGE     = 3'd4,
        ST_TRAILING  = 3'd5,
        ST_NO_FIELDS = 3'd6,
        ST_BROKEN    = 3'd7
    } status_t;

    // One result item.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_out;
        field_idx_t field_index;
        length_t    frame_length;
        status_t    status;
        logic       last;
    } result_t;

    // Results produced by one input byte, in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// File: rtl/bdmd_parse.sv
// Frame parser: state registers and per-byte result generation.
module bdmd_parse #(
    parameter int MAX_FIELDS = 20,
    parameter int TYPE_CHARS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [6:0]           cfg_data,
    input  logic                 in_accept,
    input  logic [7:0]           in_byte,
    input  logic                 in_broken,
    output bdmd_pkg::push_t      push
);

    localparam int FW  = $clog2(MAX_FIELDS + 1);
    localparam int TCW = $clog2(TYPE_CHARS + 1);

    bdmd_pkg::phase_t  phase_reg, phase_next;
    logic [3:0]        tens_reg, tens_next;
    bdmd_pkg::length_t length_reg, length_next;
    bdmd_pkg::length_t left_reg, left_next;
    logic [FW-1:0]     fields_reg, fields_next;
    logic [TCW-1:0]    chars_reg, chars_next;
    logic              in_token_reg, in_token_next;
    bdmd_pkg::length_t max_length_reg;

    // Step logic locals.
    logic               is_digit;
    logic [3:0]         digit;
    bdmd_pkg::length_t  decoded;
    logic               a_valid, b_valid, do_clear;
    bdmd_pkg::result_t  res_a, res_b;
    logic [FW-1:0]      field_m1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= bdmd_pkg::MAX_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            max_length_reg <= cfg_data;
        end
    end

    // Frame state registers, updated on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= bdmd_pkg::PH_VERSION;
            tens_reg     <= '0;
            length_reg   <= '0;
            left_reg     <= '0;
            fields_reg   <= '0;
            chars_reg    <= '0;
            in_token_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg    <= phase_next;
            tens_reg     <= tens_next;
            length_reg   <= length_next;
            left_reg     <= left_next;
            fields_reg   <= fields_next;
            chars_reg    <= chars_next;
            in_token_reg <= in_token_next;
        end
    end

    // Digit decode and length from two digits: tens * 10 + units.
    assign is_digit = (in_byte >= bdmd_pkg::CH_VERSION) && (in_byte <= bdmd_pkg::CH_NINE);
    assign digit    = in_byte[3:0];
    assign decoded  = bdmd_pkg::length_t'({tens_reg, 3'b000})
                    + bdmd_pkg::length_t'({tens_reg, 1'b0})
                    + bdmd_pkg::length_t'(digit);

    // Next state and results for the byte at the input.
    always_comb
    begin
        phase_next    = phase_reg;
        tens_next     = tens_reg;
        length_next   = length_reg;
        left_next     = left_reg;
        fields_next   = fields_reg;
        chars_next    = chars_reg;
        in_token_next = in_token_reg;
        a_valid       = 1'b0;
        b_valid       = 1'b0;
        do_clear      = 1'b0;
        res_a         = '0;
        res_b         = '0;
        field_m1      = '0;
        res_b.kind         = bdmd_pkg::KIND_REJECT;
        res_b.frame_length = length_reg;

        if (in_broken)
        begin
            b_valid      = 1'b1;
            res_b.status = bdmd_pkg::ST_BROKEN;
            do_clear     = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                bdmd_pkg::PH_VERSION:
                begin
                    if (in_byte == bdmd_pkg::CH_VERSION)
                    begin
                        phase_next = bdmd_pkg::PH_BAR1;
                    end
                    else
                    begin
                        b_valid      = 1'b1;
                        res_b.status = bdmd_pkg::ST_VERSION;
                        do_clear     = 1'b1;
                    end
                end
                bdmd_pkg::PH_BAR1,
                bdmd_pkg::PH_BAR2:
                begin
                    if (in_byte == bdmd_pkg::CH_BAR)
                    begin
                        phase_next = (phase_reg == bdmd_pkg::PH_BAR1) ?
                                     bdmd_pkg::PH_TENS : bdmd_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        b_valid      = 1'b1;
                        res_b.status = bdmd_pkg::ST_SEPARATOR;
                        do_clear     = 1'b1;
                    end
                end
                bdmd_pkg::PH_TENS:
                begin
                    if (is_digit)
                    begin
                        tens_next  = digit;
                        phase_next = bdmd_pkg::PH_UNITS;
                    end
                    else
                    begin
                        b_valid      = 1'b1;
                        res_b.status = bdmd_pkg::ST_DIGIT;
                        do_clear     = 1'b1;
                    end
                end
                bdmd_pkg::PH_UNITS:
                begin
                    if (!is_digit)
                    begin
                        b_valid      = 1'b1;
                        res_b.status = bdmd_pkg::ST_DIGIT;
                        do_clear     = 1'b1;
                    end
                    else if ((decoded == '0) || (decoded > max_length_reg))
                    begin
                        // Out-of-range length reports the decoded value.
                        b_valid            = 1'b1;
                        res_b.status       = bdmd_pkg::ST_RANGE;
                        res_b.frame_length = decoded;
                        do_clear           = 1'b1;
                    end
                    else
                    begin
                        length_next = decoded;
                        left_next   = decoded;
                        phase_next  = bdmd_pkg::PH_BAR2;
                    end
                end
                bdmd_pkg::PH_PAYLOAD:
                begin
                    if (in_byte == bdmd_pkg::CH_BAR)
                    begin
                        // A bar closes an open field; runs of bars do nothing.
                        if (in_token_reg)
                        begin
                            field_m1          = fields_reg - FW'(1);
                            a_valid           = 1'b1;
                            res_a.kind        = bdmd_pkg::KIND_END;
                            res_a.field_index = bdmd_pkg::field_idx_t'(field_m1);
                            in_token_next     = 1'b0;
                        end
                    end
                    else
                    begin
                        // Open a new field while there is room for one.
                        if (!in_token_reg && (fields_reg < FW'(MAX_FIELDS)))
                        begin
                            fields_next   = fields_reg + FW'(1);
                            in_token_next = 1'b1;
                            chars_next    = '0;
                        end
                        if (in_token_next)
                        begin
                            field_m1 = fields_next - FW'(1);
                            if ((fields_next != FW'(1)) || (chars_next < TCW'(TYPE_CHARS)))
                            begin
                                a_valid           = 1'b1;
                                res_a.kind        = bdmd_pkg::KIND_BYTE;
                                res_a.char_out    = in_byte;
                                res_a.field_index = bdmd_pkg::field_idx_t'(field_m1);
                            end
                            // Count saturates once the type field limit is reached.
                            if (chars_next < TCW'(TYPE_CHARS))
                            begin
                                chars_next = chars_next + TCW'(1);
                            end
                        end
                    end

                    // Close the frame on its last payload byte.
                    left_next = left_reg - 7'd1;
                    if (left_next == '0)
                    begin
                        b_valid  = 1'b1;
                        do_clear = 1'b1;
                        if (in_byte != bdmd_pkg::CH_BAR)
                        begin
                            res_b.status = bdmd_pkg::ST_TRAILING;
                        end
                        else if (fields_next == '0)
                        begin
                            res_b.status = bdmd_pkg::ST_NO_FIELDS;
                        end
                        else
                        begin
                            res_b.kind = bdmd_pkg::KIND_ACCEPT;
                        end
                    end
                end
                default:
                begin
                    b_valid      = 1'b1;
                    res_b.status = bdmd_pkg::ST_VERSION;
                    do_clear     = 1'b1;
                end
            endcase
        end

        if (do_clear)
        begin
            phase_next    = bdmd_pkg::PH_VERSION;
            tens_next     = '0;
            length_next   = '0;
            left_next     = '0;
            fields_next   = '0;
            chars_next    = '0;
            in_token_next = 1'b0;
        end
    end

    // Order the results and mark the final one.
    always_comb
    begin
        push = '0;
        if (a_valid && b_valid)
        begin
            push.count       = 2'd2;
            push.first       = res_a;
            push.second      = res_b;
            push.second.last = 1'b1;
        end
        else if (a_valid)
        begin
            push.count      = 2'd1;
            push.first      = res_a;
            push.first.last = 1'b1;
        end
        else if (b_valid)
        begin
            push.count      = 2'd1;
            push.first      = res_b;
            push.first.last = 1'b1;
        end
    end

endmodule

// File: rtl/bdmd_outq.sv
// Result queue: takes up to two results per cycle and hands out one.
module bdmd_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_en,
    input  bdmd_pkg::push_t     push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output bdmd_pkg::result_t   out_data
);

    localparam int AW = $clog2(bdmd_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(bdmd_pkg::QUEUE_DEPTH + 1);

    bdmd_pkg::result_t mem [bdmd_pkg::QUEUE_DEPTH];

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    wr_cnt;
    logic          pop;

    assign wr_cnt    = push_en ? push.count : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[head_reg];

    // Room for the largest burst one byte can cause.
    assign room = (count_reg <= CW'(bdmd_pkg::QUEUE_DEPTH - 2));

    // Pointer and fill count updates.
    always_comb
    begin
        head_next  = head_reg + AW'(pop);
        tail_next  = tail_reg + AW'(wr_cnt);
        count_next = count_reg + CW'(wr_cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            mem[tail_reg] <= push.first;
        end
        if (wr_cnt == 2'd2)
        begin
            mem[tail_reg + AW'(1)] <= push.second;
        end
    end

endmodule

// File: rtl/bar_delimited_message_deframer.sv
// Top level of the bar-delimited message deframer.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       tdata: data_byte; tuser: stream_broken
//   m_axis    out        m_axis_tvalid/tready       tdata/tuser/tlast: one result
//   cfg       in         cfg_valid/cfg_ready        cfg_data: max_length
//
// One byte is parsed per cycle by single-level logic between the frame state
// registers and a four-entry result queue, which holds the results until taken.
// A byte is taken whenever the queue has room for two results, so a steady
// one byte per cycle is sustained while the output side keeps up.
// Reset clears the frame state, the queue and sets max_length to 99.
// The configuration channel is always ready.
module bar_delimited_message_deframer #(
    parameter int MAX_FIELDS = 20,
    parameter int TYPE_CHARS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] stream_broken
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] char_out, [12:8] field_index,
                                        // [19:13] frame_length, [22:20] status, [23] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    bdmd_pkg::push_t   push;
    bdmd_pkg::result_t head;
    logic              room;
    logic              in_accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = room;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Parser with its state and the configuration register.
    bdmd_parse #(
        .MAX_FIELDS (MAX_FIELDS),
        .TYPE_CHARS (TYPE_CHARS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_byte   (s_axis_tdata),
        .in_broken (s_axis_tuser),
        .push      (push)
    );

    // Result queue decoupling the output side.
    bdmd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (in_accept),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    // Output packing.
    assign m_axis_tdata = {1'b0, head.status, head.frame_length, head.field_index,
                           head.char_out};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

// File: tb/bar_delimited_message_deframer_tb.sv
// Self-checking testbench for the bar-delimited message deframer.
module bar_delimited_message_deframer_tb;

    localparam int MAX_FIELDS   = 20;
    localparam int TYPE_CHARS   = 4;
    localparam int RANDOM_ITEMS = 1420;
    localparam int CALM_ITEMS   = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int IDLE_PCT     = 18;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data      = 7'd0;

    // When set, neither side inserts idle cycles.
    logic        calm          = 1'b0;

    // Results the deframer owes, oldest first, and the ones the current byte causes.
    bdmd_pkg::result_t expected_results[$];
    bdmd_pkg::result_t step_results[$];

    int unsigned items_sent   = 0;
    int unsigned mismatches   = 0;
    int unsigned stall_cycles = 0;

    // Parser state mirrored by the predictor.
    bdmd_pkg::phase_t  parse_phase;
    int unsigned       tens_value;
    bdmd_pkg::length_t frame_len;
    bdmd_pkg::length_t bytes_remaining;
    int unsigned       field_count;
    int unsigned       field_chars;
    bit                field_open;
    bdmd_pkg::length_t max_len_setting;

    bar_delimited_message_deframer #(
        .MAX_FIELDS (MAX_FIELDS),
        .TYPE_CHARS (TYPE_CHARS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Return the parser to waiting for a version byte.
    function automatic void clear_frame();
        parse_phase     = bdmd_pkg::PH_VERSION;
        tens_value      = 0;
        frame_len       = '0;
        bytes_remaining = '0;
        field_count     = 0;
        field_chars     = 0;
        field_open      = 1'b0;
    endfunction

    function automatic void add_result(input bdmd_pkg::kind_t k, input logic [7:0] ch,
                                       input int unsigned idx,
                                       input bdmd_pkg::length_t len,
                                       input bdmd_pkg::status_t st);
        bdmd_pkg::result_t r;
        r.kind         = k;
        r.char_out     = ch;
        r.field_index  = bdmd_pkg::field_idx_t'(idx);
        r.frame_length = len;
        r.status       = st;
        r.last         = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void reject_frame(input bdmd_pkg::status_t st);
        add_result(bdmd_pkg::KIND_REJECT, 8'h00, 0, frame_len, st);
        clear_frame();
    endfunction

    // Work out the results caused by one accepted byte and queue them.
    function automatic void predict_byte(input logic [7:0] b, input logic broken);
        int unsigned total;
        step_results.delete();
        if (broken)
        begin
            reject_frame(bdmd_pkg::ST_BROKEN);
        end
        else
        begin
            case (parse_phase)
                bdmd_pkg::PH_VERSION:
                    if (b == bdmd_pkg::CH_VERSION) parse_phase = bdmd_pkg::PH_BAR1;
                    else reject_frame(bdmd_pkg::ST_VERSION);
                bdmd_pkg::PH_BAR1:
                    if (b == bdmd_pkg::CH_BAR) parse_phase = bdmd_pkg::PH_TENS;
                    else reject_frame(bdmd_pkg::ST_SEPARATOR);
                bdmd_pkg::PH_TENS:
                    if (b >= bdmd_pkg::CH_VERSION && b <= bdmd_pkg::CH_NINE)
                    begin
                        tens_value  = b - bdmd_pkg::CH_VERSION;
                        parse_phase = bdmd_pkg::PH_UNITS;
                    end
                    else
                    begin
                        reject_frame(bdmd_pkg::ST_DIGIT);
                    end
                bdmd_pkg::PH_UNITS:
                    if (b >= bdmd_pkg::CH_VERSION && b <= bdmd_pkg::CH_NINE)
                    begin
                        total     = tens_value * 10 + (b - bdmd_pkg::CH_VERSION);
                        frame_len = bdmd_pkg::length_t'(total);
                        if (total == 0 || total > max_len_setting)
                        begin
                            reject_frame(bdmd_pkg::ST_RANGE);
                        end
                        else
                        begin
                            bytes_remaining = frame_len;
                            parse_phase     = bdmd_pkg::PH_BAR2;
                        end
                    end
                    else
                    begin
                        reject_frame(bdmd_pkg::ST_DIGIT);
                    end
                bdmd_pkg::PH_BAR2:
                    if (b == bdmd_pkg::CH_BAR) parse_phase = bdmd_pkg::PH_PAYLOAD;
                    else reject_frame(bdmd_pkg::ST_SEPARATOR);
                default:
                begin
                    // A bar closes an open field; other bytes open or extend one.
                    if (b == bdmd_pkg::CH_BAR)
                    begin
                        if (field_open)
                        begin
                            add_result(bdmd_pkg::KIND_END, 8'h00, field_count - 1, '0,
                                       bdmd_pkg::ST_OK);
                            field_open = 1'b0;
                        end
                    end
                    else
                    begin
                        if (!field_open && field_count < MAX_FIELDS)
                        begin
                            field_count++;
                            field_open  = 1'b1;
                            field_chars = 0;
                        end
                        if (field_open)
                        begin
                            if (field_count != 1 || field_chars < TYPE_CHARS)
                                add_result(bdmd_pkg::KIND_BYTE, b, field_count - 1, '0,
                                           bdmd_pkg::ST_OK);
                            if (field_chars < 127)
                                field_chars++;
                        end
                    end
                    // The last payload byte decides the outcome of the frame.
                    if (bytes_remaining > 0)
                        bytes_remaining--;
                    if (bytes_remaining == 0)
                    begin
                        if (b != bdmd_pkg::CH_BAR)
                            reject_frame(bdmd_pkg::ST_TRAILING);
                        else if (field_count == 0)
                            reject_frame(bdmd_pkg::ST_NO_FIELDS);
                        else
                        begin
                            add_result(bdmd_pkg::KIND_ACCEPT, 8'h00, 0, frame_len,
                                       bdmd_pkg::ST_OK);
                            clear_frame();
                        end
                    end
                end
            endcase
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            expected_results.push_back(step_results[i]);
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        bdmd_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result: expected none, actual kind %0d", m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, m_axis_tuser);
                check_field("char_out", want.char_out, m_axis_tdata[7:0]);
                check_field("field_index", want.field_index, m_axis_tdata[12:8]);
                check_field("frame_length", want.frame_length, m_axis_tdata[19:13]);
                check_field("status", want.status, m_axis_tdata[22:20]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // Output side backpressure.
    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // Count cycles in which no transfer happens on any channel.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("bar_delimited_message_deframer_tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Offer one byte, possibly after idle cycles, and predict once it transfers.
    task automatic send_byte(input logic [7:0] b, input logic broken);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= broken;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        predict_byte(b, broken);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // Hold the input side quiet until every owed result has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [6:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid       <= 1'b0;
        max_len_setting = value;
        @(posedge clk);
    endtask

    function automatic logic [7:0] random_non_bar();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == bdmd_pkg::CH_BAR)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // One frame with random content; a minority are corrupted or cut by a break.
    task automatic send_random_frame();
        logic [7:0]  hdr[5];
        logic [7:0]  b;
        int unsigned roll, plen, bar_pct, spot, stop_at, limit;
        bit          corrupt, broken_frame;
        if ($urandom_range(99) < 5)
            send_byte(8'($urandom_range(255)), 1'b0);
        roll  = $urandom_range(99);
        limit = (max_len_setting < 16) ? max_len_setting : 16;
        if (roll < 3)
            plen = 0;
        else if (roll < 15)
            plen = $urandom_range(99, 1);
        else
            plen = $urandom_range(limit, 1);
        hdr[0] = bdmd_pkg::CH_VERSION;
        hdr[1] = bdmd_pkg::CH_BAR;
        hdr[2] = 8'(bdmd_pkg::CH_VERSION + plen / 10);
        hdr[3] = 8'(bdmd_pkg::CH_VERSION + plen % 10);
        hdr[4] = bdmd_pkg::CH_BAR;
        corrupt = ($urandom_range(99) < 8);
        if (corrupt)
            hdr[$urandom_range(4)] = 8'($urandom_range(255));
        broken_frame = ($urandom_range(99) < 3);
        spot         = $urandom_range(4 + plen);
        bar_pct      = ($urandom_range(99) < 15) ? 50 : 20;
        stop_at      = (corrupt || plen == 0 || plen > max_len_setting) ? 5 : 5 + plen;
        for (int unsigned pos = 0; pos < stop_at; pos++)
        begin
            if (pos < 5)
                b = hdr[pos];
            else if (pos == 4 + plen)
                b = ($urandom_range(99) < 85) ? bdmd_pkg::CH_BAR : random_non_bar();
            else
                b = ($urandom_range(99) < bar_pct) ? bdmd_pkg::CH_BAR : random_non_bar();
            if (broken_frame && pos == spot)
            begin
                send_byte(b, 1'b1);
                return;
            end
            send_byte(b, 1'b0);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Each reject status once, with the byte extremes.
    task automatic test_error_paths();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_text("0|00");
        send_text("0x");
        send_text("0|4A");
        send_text("0|02|ab");
        send_text("0|01||");
        drain_results();
    endtask

    // Smallest and largest length limits, long type field and dropped fields.
    task automatic test_length_limits();
        write_max_length(7'd1);
        send_text("0|01|x");
        send_text("0|02|");
        send_text("0|01||");
        write_max_length(7'd99);
        send_text("0|99|typename|");
        repeat (45) send_text("a|");
        write_max_length(7'd28);
        send_text("0|28|cmd|");
        repeat (9) send_text("zy|");
        send_text("0|29|");
        drain_results();
    endtask

    // Mostly well-formed frames, with noise, breaks, pauses and limit changes.
    task automatic test_random_traffic();
        int unsigned start;
        start = items_sent;
        calm <= 1'b1;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if (items_sent - start >= CALM_ITEMS)
                calm <= 1'b0;
            send_random_frame();
            if ($urandom_range(99) < 4)
                drain_results();
            if ($urandom_range(99) < 3)
                write_max_length(7'($urandom_range(99, 1)));
        end
        drain_results();
    endtask

    initial
    begin
        max_len_setting = bdmd_pkg::MAX_LENGTH_RESET;
        clear_frame();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_error_paths();
        test_length_limits();
        test_random_traffic();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("bar_delimited_message_deframer_tb: PASS");
        else
            $display("bar_delimited_message_deframer_tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/bdmd_pkg.sv
rtl/bdmd_parse.sv
rtl/bdmd_outq.sv
rtl/bar_delimited_message_deframer.sv
tb/bar_delimited_message_deframer_tb.sv
